[sv/i2cms_pkg.sv]
// i2cms_pkg: command codes and the sequencer state record
// no dependencies; imported by the step logic and the top level
package i2cms_pkg;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_WRITE = 3'd3,
		CMD_READ  = 3'd4,
		CMD_SACK  = 3'd5,
		CMD_RACK  = 3'd6
	} cmd_t;

	localparam logic [4:0] START_LAST = 5'd3;
	localparam logic [4:0] STOP_LAST  = 5'd2;
	localparam logic [4:0] WRITE_LAST = 5'd23;
	localparam logic [4:0] READ_LAST  = 5'd16;
	localparam logic [4:0] ACK_LAST   = 5'd2;

	typedef struct packed {
		cmd_t       active;
		logic [4:0] phase;
		logic [1:0] sub;       // phase modulo three, for write byte
		logic [7:0] shift;
		logic       last_ack;
		logic       scl;
		logic       sda;
		logic [7:0] rx_data;
		logic       ack_level;
	} state_t;

	localparam state_t STATE_RESET = '{
		active:    CMD_NONE,
		phase:     5'd0,
		sub:       2'd0,
		shift:     8'h00,
		last_ack:  1'b1,
		scl:       1'b1,
		sda:       1'b1,
		rx_data:   8'h00,
		ack_level: 1'b0
	};

endpackage

[sv/i2cms_tick_if.sv]
// i2cms_tick_if: valid/ready channel carrying one bus tick word
// no dependencies
interface i2cms_tick_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] tx_byte;
	logic       ack_out;
	logic       sda_in;

	modport source (output valid, cmd, tx_byte, ack_out, sda_in, input ready);
	modport sink   (input valid, cmd, tx_byte, ack_out, sda_in, output ready);
endinterface

[sv/i2cms_result_if.sv]
// i2cms_result_if: valid/ready channel carrying one result word
// no dependencies
interface i2cms_result_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       rx_ack;
	logic       cmd_ignored;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		rx_ack, cmd_ignored, input ready);
	modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		rx_ack, cmd_ignored, output ready);
endinterface

[sv/i2cms_step.sv]
// i2cms_step: next-state logic for one bus tick (command latch and one pin change)
// depends on i2cms_pkg
module i2cms_step
	import i2cms_pkg::*;
(
	input  state_t     cur,
	input  logic [2:0] cmd,
	input  logic [7:0] tx_byte,
	input  logic       ack_out,
	input  logic       sda_in,
	output state_t     nxt,
	output logic       done,
	output logic       ignored
);

	logic last;

	always_comb begin
		nxt     = cur;
		ignored = 1'b0;
		last    = 1'b0;

		if (cur.active != CMD_NONE) begin
			ignored = (cmd != CMD_NONE);
		end else if (cmd inside {[CMD_START:CMD_RACK]}) begin
			nxt.active = cmd_t'(cmd);
			nxt.phase  = 5'd0;
			nxt.sub    = 2'd0;
			if (cmd == CMD_WRITE)
				nxt.shift = tx_byte;
			else if (cmd == CMD_READ)
				nxt.shift = 8'h00;
			if (cmd == CMD_SACK)
				nxt.ack_level = ack_out;
		end

		case (nxt.active)
			CMD_START: begin
				case (nxt.phase)
					5'd0:    nxt.sda = 1'b1;
					5'd1:    nxt.scl = 1'b1;
					5'd2:    nxt.sda = 1'b0;
					default: nxt.scl = 1'b0;
				endcase
				last = (nxt.phase >= START_LAST);
			end
			CMD_STOP: begin
				case (nxt.phase)
					5'd0:    nxt.sda = 1'b0;
					5'd1:    nxt.scl = 1'b1;
					default: nxt.sda = 1'b1;
				endcase
				last = (nxt.phase >= STOP_LAST);
			end
			CMD_WRITE: begin
				case (nxt.sub)
					2'd0: nxt.sda = nxt.shift[7];
					2'd1: nxt.scl = 1'b1;
					default: begin
						nxt.scl   = 1'b0;
						nxt.shift = {nxt.shift[6:0], 1'b0};
					end
				endcase
				last = (nxt.phase >= WRITE_LAST);
			end
			CMD_READ: begin
				if (nxt.phase == 5'd0) begin
					nxt.sda = 1'b1;
				end else if (nxt.phase[0]) begin
					nxt.scl = 1'b1;
				end else begin
					// falling edge of scl: sample the bit
					nxt.scl   = 1'b0;
					nxt.shift = {nxt.shift[6:0], sda_in};
					if (nxt.phase >= READ_LAST) begin
						nxt.rx_data = nxt.shift;
						last        = 1'b1;
					end
				end
			end
			CMD_SACK: begin
				case (nxt.phase)
					5'd0:    nxt.sda = nxt.ack_level;
					5'd1:    nxt.scl = 1'b1;
					default: nxt.scl = 1'b0;
				endcase
				last = (nxt.phase >= ACK_LAST);
			end
			CMD_RACK: begin
				case (nxt.phase)
					5'd0:    nxt.sda = 1'b1;
					5'd1:    nxt.scl = 1'b1;
					default: begin
						nxt.scl      = 1'b0;
						nxt.last_ack = sda_in;
					end
				endcase
				last = (nxt.phase >= ACK_LAST);
			end
			default: last = 1'b0;
		endcase

		done = (nxt.active != CMD_NONE) && last;
		if (nxt.active != CMD_NONE) begin
			if (last) begin
				nxt.active = CMD_NONE;
				nxt.phase  = 5'd0;
			end else begin
				nxt.phase = nxt.phase + 5'd1;
				nxt.sub   = (nxt.sub == 2'd2) ? 2'd0 : nxt.sub + 2'd1;
			end
		end
	end

endmodule

[sv/i2c_master_bit_sequencer.sv]
// i2c_master_bit_sequencer: a tick passes the input register, then the step logic into the
// result register before its result is valid; one tick per cycle sustained while the result
// channel does not stall, set by the state update loop through i2cms_step
// arst_n clears both stages and returns the sequencer to idle with scl and sda released
// depends on i2cms_pkg, i2cms_tick_if, i2cms_result_if and i2cms_step
module i2c_master_bit_sequencer
	import i2cms_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	i2cms_tick_if.sink      tick,
	i2cms_result_if.source  result
);

	logic       valid_s1;
	logic [2:0] cmd_s1;
	logic [7:0] tx_byte_s1;
	logic       ack_out_s1;
	logic       sda_in_s1;

	state_t     state_q;
	state_t     state_nxt;
	logic       done_nxt;
	logic       ignored_nxt;

	logic       res_valid_q;
	logic       scl_q;
	logic       sda_q;
	logic       busy_q;
	logic       done_q;
	logic [7:0] rx_byte_q;
	logic       rx_ack_q;
	logic       ignored_q;

	logic       advance;

	// the stage moves on when the result register is empty or being drained
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			cmd_s1     <= tick.cmd;
			tx_byte_s1 <= tick.tx_byte;
			ack_out_s1 <= tick.ack_out;
			sda_in_s1  <= tick.sda_in;
		end
	end

	i2cms_step u_step (
		.cur     (state_q),
		.cmd     (cmd_s1),
		.tx_byte (tx_byte_s1),
		.ack_out (ack_out_s1),
		.sda_in  (sda_in_s1),
		.nxt     (state_nxt),
		.done    (done_nxt),
		.ignored (ignored_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (advance)
				state_q <= state_nxt;
			if (advance)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_q     <= state_nxt.scl;
			sda_q     <= state_nxt.sda;
			busy_q    <= (state_nxt.active != CMD_NONE);
			done_q    <= done_nxt;
			rx_byte_q <= state_nxt.rx_data;
			rx_ack_q  <= state_nxt.last_ack;
			ignored_q <= ignored_nxt;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.scl_level   = scl_q;
	assign result.sda_level   = sda_q;
	assign result.busy_res    = busy_q;
	assign result.done_res    = done_q;
	assign result.rx_byte     = rx_byte_q;
	assign result.rx_ack      = rx_ack_q;
	assign result.cmd_ignored = ignored_q;

endmodule

[tb/i2cms_pin_check.sv]
`timescale 1ns / 1ps
// i2cms_pin_check: watches the tick and result channels of the sequencer, predicts
// pins and flags for every accepted tick and compares each result word in order
// depends on i2cms_pkg, i2cms_tick_if and i2cms_result_if
module i2cms_pin_check
	import i2cms_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	i2cms_tick_if   tick,
	i2cms_result_if result,
	output int      mismatches,
	output int      outstanding
);

	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rx_byte;
		logic       rx_ack;
		logic       ignored;
	} pins_t;

	cmd_t       run_cmd;
	logic [4:0] phase;
	logic [7:0] shreg;
	logic [7:0] rx_hold;
	logic       ack_seen;
	logic       ack_to_send;
	logic       scl_drv;
	logic       sda_drv;
	pins_t      pins_q[$];
	int         err_count = 0;

	assign mismatches = err_count;

	task automatic report_mismatch(input string field, input int got, input int want);
		$display("%0t: %s mismatch, got %0h, expected %0h", $time, field, got, want);
		err_count++;
	endtask

	function automatic pins_t predict_pins(input logic [2:0] cmd, input logic [7:0] tx,
		input logic ack, input logic sda_bit);
		pins_t p;
		logic  last;
		p.ignored = 1'b0;
		p.done    = 1'b0;
		last      = 1'b0;
		if (run_cmd != CMD_NONE) begin
			if (cmd != CMD_NONE)
				p.ignored = 1'b1;
		end else if (cmd >= CMD_START && cmd <= CMD_RACK) begin
			run_cmd = cmd_t'(cmd);
			phase   = 5'd0;
			if (run_cmd == CMD_WRITE)
				shreg = tx;
			else if (run_cmd == CMD_READ)
				shreg = 8'h00;
			if (run_cmd == CMD_SACK)
				ack_to_send = ack;
		end
		if (run_cmd != CMD_NONE) begin
			case (run_cmd)
				CMD_START: begin
					case (phase)
						5'd0: sda_drv = 1'b1;
						5'd1: scl_drv = 1'b1;
						5'd2: sda_drv = 1'b0;
						default: scl_drv = 1'b0;
					endcase
					last = (phase >= START_LAST);
				end
				CMD_STOP: begin
					case (phase)
						5'd0: sda_drv = 1'b0;
						5'd1: scl_drv = 1'b1;
						default: sda_drv = 1'b1;
					endcase
					last = (phase >= STOP_LAST);
				end
				CMD_WRITE: begin
					case (phase % 5'd3)
						5'd0: sda_drv = shreg[7];
						5'd1: scl_drv = 1'b1;
						default: begin
							scl_drv = 1'b0;
							shreg   = {shreg[6:0], 1'b0};
						end
					endcase
					last = (phase >= WRITE_LAST);
				end
				CMD_READ: begin
					// release sda, then odd phases raise scl and even phases sample
					if (phase == 5'd0)
						sda_drv = 1'b1;
					else if (phase[0])
						scl_drv = 1'b1;
					else begin
						scl_drv = 1'b0;
						shreg   = {shreg[6:0], sda_bit};
						if (phase >= READ_LAST) begin
							rx_hold = shreg;
							last    = 1'b1;
						end
					end
				end
				CMD_SACK: begin
					case (phase)
						5'd0: sda_drv = ack_to_send;
						5'd1: scl_drv = 1'b1;
						default: scl_drv = 1'b0;
					endcase
					last = (phase >= ACK_LAST);
				end
				CMD_RACK: begin
					case (phase)
						5'd0: sda_drv = 1'b1;
						5'd1: scl_drv = 1'b1;
						default: begin
							scl_drv  = 1'b0;
							ack_seen = sda_bit;
						end
					endcase
					last = (phase >= ACK_LAST);
				end
				default: last = 1'b1;
			endcase
			if (last) begin
				p.done  = 1'b1;
				run_cmd = CMD_NONE;
				phase   = 5'd0;
			end else
				phase = phase + 5'd1;
		end
		p.scl     = scl_drv;
		p.sda     = sda_drv;
		p.busy    = (run_cmd != CMD_NONE);
		p.rx_byte = rx_hold;
		p.rx_ack  = ack_seen;
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pins_t want;
		pins_t got;
		if (!arst_n) begin
			run_cmd     = CMD_NONE;
			phase       = 5'd0;
			shreg       = 8'h00;
			rx_hold     = 8'h00;
			ack_seen    = 1'b1;
			ack_to_send = 1'b0;
			scl_drv     = 1'b1;
			sda_drv     = 1'b1;
			pins_q.delete();
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready) begin
				got = '{result.scl_level, result.sda_level, result.busy_res, result.done_res,
					result.rx_byte, result.rx_ack, result.cmd_ignored};
				if (pins_q.size() == 0)
					report_mismatch("unexpected word", got, 0);
				else begin
					want = pins_q.pop_front();
					if (got.scl !== want.scl)
						report_mismatch("scl_level", got.scl, want.scl);
					if (got.sda !== want.sda)
						report_mismatch("sda_level", got.sda, want.sda);
					if (got.busy !== want.busy)
						report_mismatch("busy_res", got.busy, want.busy);
					if (got.done !== want.done)
						report_mismatch("done_res", got.done, want.done);
					if (got.rx_byte !== want.rx_byte)
						report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
					if (got.rx_ack !== want.rx_ack)
						report_mismatch("rx_ack", got.rx_ack, want.rx_ack);
					if (got.ignored !== want.ignored)
						report_mismatch("cmd_ignored", got.ignored, want.ignored);
				end
			end
			if (tick.valid && tick.ready)
				pins_q.push_back(predict_pins(tick.cmd, tick.tx_byte, tick.ack_out, tick.sda_in));
			outstanding <= pins_q.size();
		end
	end

endmodule

[tb/tb_i2c_master_bit_sequencer.sv]
`timescale 1ns / 1ps
// tb_i2c_master_bit_sequencer: drives bus tick words into the sequencer and gives the verdict
// depends on i2cms_pkg, the channel interfaces, the sequencer and i2cms_pin_check
module tb_i2c_master_bit_sequencer;
	import i2cms_pkg::*;

	// code seven lies outside the command set
	localparam logic [2:0] CMD_UNUSED = 3'd7;

	logic clk;
	logic arst_n;
	int   mismatches;
	int   outstanding;
	int   gap_pct   = 0;
	int   stall_pct = 0;
	int   busy_left = 0;

	i2cms_tick_if   tick_ch();
	i2cms_result_if result_ch();

	i2c_master_bit_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch)
	);

	i2cms_pin_check pin_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick_ch),
		.result      (result_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_i2c_master_bit_sequencer: FAIL");
		$finish;
	end

	always @(posedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	function automatic int command_ticks(input logic [2:0] cmd);
		case (cmd)
			CMD_START: return START_LAST + 1;
			CMD_STOP:  return STOP_LAST + 1;
			CMD_WRITE: return WRITE_LAST + 1;
			CMD_READ:  return READ_LAST + 1;
			CMD_SACK:  return ACK_LAST + 1;
			CMD_RACK:  return ACK_LAST + 1;
			default:   return 1;
		endcase
	endfunction

	task automatic send_tick(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
		input logic sda);
		while ($urandom_range(99) < gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(posedge clk);
		end
		tick_ch.valid   <= 1'b1;
		tick_ch.cmd     <= cmd;
		tick_ch.tx_byte <= tx;
		tick_ch.ack_out <= ack;
		tick_ch.sda_in  <= sda;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
	endtask

	// one command followed by enough ticks to finish it, noise sent on every busy tick
	task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
		input logic sda, input logic [2:0] noise);
		send_tick(cmd, tx, ack, sda);
		for (int i = 1; i < command_ticks(cmd); i++)
			send_tick(noise, 8'($urandom), 1'($urandom), sda);
	endtask

	// mostly well-formed command runs, with dropped commands and code seven mixed in
	task automatic random_tick();
		logic [2:0] cmd;
		int         roll;
		roll = $urandom_range(99);
		if (busy_left == 0) begin
			if (roll < 82)
				cmd = 3'($urandom_range(CMD_START, CMD_RACK));
			else if (roll < 88)
				cmd = CMD_UNUSED;
			else
				cmd = CMD_NONE;
		end else
			cmd = (roll < 8) ? 3'($urandom_range(CMD_START, CMD_UNUSED)) : CMD_NONE;
		send_tick(cmd, 8'($urandom), 1'($urandom), 1'($urandom));
		if (busy_left > 0)
			busy_left--;
		else
			busy_left = command_ticks(cmd) - 1;
	endtask

	initial begin
		arst_n = 1'b0;
		tick_ch.valid   <= 1'b0;
		tick_ch.cmd     <= CMD_NONE;
		tick_ch.tx_byte <= 8'h00;
		tick_ch.ack_out <= 1'b0;
		tick_ch.sda_in  <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		run_command(CMD_NONE, 8'h00, 1'b0, 1'b0, CMD_NONE);
		run_command(CMD_UNUSED, 8'hFF, 1'b1, 1'b1, CMD_NONE);
		run_command(CMD_START, 8'h00, 1'b0, 1'b0, CMD_NONE);
		run_command(CMD_WRITE, 8'hFF, 1'b0, 1'b0, CMD_NONE);
		run_command(CMD_WRITE, 8'h00, 1'b1, 1'b1, CMD_NONE);
		run_command(CMD_RACK, 8'h00, 1'b0, 1'b0, CMD_NONE);
		run_command(CMD_READ, 8'h00, 1'b0, 1'b1, CMD_NONE);
		run_command(CMD_SACK, 8'h00, 1'b0, 1'b0, CMD_NONE);
		run_command(CMD_READ, 8'hFF, 1'b1, 1'b0, CMD_NONE);
		run_command(CMD_SACK, 8'h00, 1'b1, 1'b1, CMD_NONE);
		run_command(CMD_RACK, 8'h00, 1'b0, 1'b1, CMD_NONE);
		run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, CMD_NONE);
		// commands while busy, the finishing tick included
		run_command(CMD_START, 8'h5A, 1'b0, 1'b0, CMD_WRITE);
		run_command(CMD_SACK, 8'h00, 1'b1, 1'b0, CMD_UNUSED);
		run_command(CMD_STOP, 8'h00, 1'b0, 1'b1, CMD_RACK);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 57; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 57; end
				default: begin gap_pct = 11; stall_pct = 11; end
			endcase
			for (int i = 0; i < 384; i++)
				random_tick();
		end

		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_i2c_master_bit_sequencer: PASS");
		else
			$display("tb_i2c_master_bit_sequencer: FAIL");
		$finish;
	end

endmodule
